[src/pai_pkg.sv]
// ----------------------------------------------------------------------------
// pai_pkg: shared types and constants of the positional array
// Request and response layouts, operation and status codes, cell command.
// ----------------------------------------------------------------------------
package pai_pkg;

  // default depth and smallest capacity
  localparam int DEF_MAX_DEPTH    = 1024;
  localparam int DEF_MIN_CAPACITY = 16;

  // field widths
  localparam int POS_W  = 11;
  localparam int WORD_W = 32;
  localparam int KIND_W = 3;
  localparam int STAT_W = 2;

  // reduction group size of the read tree
  localparam int GROUP_N = 32;

  // operation kinds
  localparam logic [KIND_W-1:0] K_INSERT = 3'd0;
  localparam logic [KIND_W-1:0] K_ERASE  = 3'd1;
  localparam logic [KIND_W-1:0] K_GET    = 3'd2;
  localparam logic [KIND_W-1:0] K_SET    = 3'd3;
  localparam logic [KIND_W-1:0] K_RESIZE = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [POS_W-1:0]         position;
    logic signed [WORD_W-1:0] value;
    logic [POS_W-1:0]         resize_count;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [POS_W-1:0]         element_count;
    logic [POS_W-1:0]         capacity_now;
    logic                     is_empty;
    logic [STAT_W-1:0]        status;
  } rsp_t;

  // command broadcast to every cell
  typedef struct packed {
    logic              ins;
    logic              era;
    logic              set;
    logic              fill;
    logic [WORD_W-1:0] value;
  } cell_cmd_t;

endpackage

[src/positional_array_insert_erase.sv]
// Sequence: an accepted request (insert, erase, get, set) passes through the
//   read state to the response; a resize that shrinks the count or outgrows
//   the capacity also passes the capacity state, which doubles or halves it.
// Flow: one request at a time; the read tree's two registered levels and the
//   capacity sequencer hold off a new one until the response has been taken.
// Reset: count clears, capacity returns to its minimum; entries are not reset.
// ----------------------------------------------------------------------------
// positional_array_insert_erase: ordered array in a row of shifting cells
// Insert, erase, get, set and resize with a capacity that doubles and halves.
// ----------------------------------------------------------------------------
module positional_array_insert_erase
  import pai_pkg::*;
#(
  parameter int MAX_DEPTH    = DEF_MAX_DEPTH,
  parameter int MIN_CAPACITY = DEF_MIN_CAPACITY
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int CW = $clog2(MAX_DEPTH + 1);
  localparam int XW = (CW > POS_W) ? CW : POS_W;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_DEPTH);
  localparam logic [XW-1:0] MIN_X = XW'(MIN_CAPACITY);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED  = 2'd1;
  localparam logic [1:0] S_CAP  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state;
  logic [XW-1:0]     count;
  logic [XW-1:0]     cap;
  logic [XW-1:0]     nsz_r;
  logic              grow;
  logic              shrink;
  logic              rd_ok;
  logic [STAT_W-1:0] status;
  logic [WORD_W-1:0] rd_sum;

  logic              accept;
  logic [XW-1:0]     pos_x;
  logic [XW-1:0]     nsz_x;
  logic              ins_ok, era_ok, get_ok, set_ok, rsz_ok;
  logic [STAT_W-1:0] status_next;
  cell_cmd_t         cmd;

  logic [WORD_W-1:0] cell_data [MAX_DEPTH];
  logic [WORD_W-1:0] cell_tap  [MAX_DEPTH];

  function automatic logic [XW-1:0] cap_dbl(input logic [XW-1:0] c);
    logic [XW:0] d;
    d = {c, 1'b0};
    return (d > {1'b0, MAX_X}) ? MAX_X : d[XW-1:0];
  endfunction

  function automatic logic [XW-1:0] cap_half(input logic [XW-1:0] c);
    logic [XW-1:0] h;
    h = c >> 1;
    return (h < MIN_X) ? MIN_X : h;
  endfunction

  assign accept    = req_valid & ~req_stall;
  assign req_stall = (state != S_IDLE);
  assign pos_x     = XW'(req.position);
  assign nsz_x     = XW'(req.resize_count);

  // request decode and checks
  always_comb begin
    ins_ok = (req.kind == K_INSERT) && (count < MAX_X) && (pos_x <= count);
    era_ok = (req.kind == K_ERASE)  && (pos_x < count);
    get_ok = (req.kind == K_GET)    && (pos_x < count);
    set_ok = (req.kind == K_SET)    && (pos_x < count);
    rsz_ok = (req.kind == K_RESIZE) && (nsz_x <= MAX_X);
    status_next = ST_OK;
    case (req.kind)
      K_INSERT: begin
        if (count >= MAX_X) status_next = ST_FULL;
        else if (pos_x > count) status_next = ST_RANGE;
      end
      K_ERASE, K_GET, K_SET: begin
        if (pos_x >= count) status_next = ST_RANGE;
      end
      K_RESIZE: begin
        if (nsz_x > MAX_X) status_next = ST_RANGE;
      end
      default: status_next = ST_OK;
    endcase
  end

  // command to the cell row
  always_comb begin
    cmd.ins   = accept & ins_ok;
    cmd.era   = accept & era_ok;
    cmd.set   = accept & set_ok;
    cmd.fill  = accept & rsz_ok;
    cmd.value = req.value;
  end

  // row of cells
  genvar i;
  generate
    for (i = 0; i < MAX_DEPTH; i++) begin : g_cell
      logic [WORD_W-1:0] left_w;
      logic [WORD_W-1:0] right_w;
      if (i == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_left
        assign left_w = cell_data[i-1];
      end
      if (i == MAX_DEPTH - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_right
        assign right_w = cell_data[i+1];
      end
      pai_cell #(
        .IDX (i),
        .XW  (XW)
      ) u_cell (
        .clk        (clk),
        .cmd        (cmd),
        .pos        (pos_x),
        .fill_lo    (count),
        .fill_hi    (nsz_x),
        .from_left  (left_w),
        .from_right (right_w),
        .data       (cell_data[i]),
        .tap        (cell_tap[i])
      );
    end
  endgenerate

  // read tree, first level captures the entry before any shift
  pai_reduce #(
    .DEPTH (MAX_DEPTH)
  ) u_reduce (
    .clk      (clk),
    .load_grp (accept),
    .load_sum (state == S_RED),
    .taps     (cell_tap),
    .sum      (rd_sum)
  );

  // request latch
  always_ff @(posedge clk) begin
    if (accept) begin
      nsz_r  <= nsz_x;
      rd_ok  <= era_ok | get_ok;
      status <= status_next;
      grow   <= rsz_ok && (nsz_x > cap);
      shrink <= rsz_ok && !(nsz_x > cap) && (nsz_x < count);
    end
  end

  // sequencer, count and capacity
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      cap   <= MIN_X;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_RED;
            if (ins_ok) begin
              count <= count + 1'b1;
              if (count >= cap) cap <= cap_dbl(cap);
            end else if (era_ok) begin
              count <= count - 1'b1;
              if ((count - 1'b1) < (cap >> 2) && cap > MIN_X) cap <= cap_half(cap);
            end else if (rsz_ok) begin
              count <= nsz_x;
            end
          end
        end
        S_RED: begin
          state <= (grow | shrink) ? S_CAP : S_OUT;
        end
        S_CAP: begin
          if (grow && nsz_r > cap) begin
            cap <= cap_dbl(cap);
          end else if (shrink && nsz_r < (cap >> 2) && cap > MIN_X) begin
            cap <= cap_half(cap);
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!rsp_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // response
  assign rsp_valid          = (state == S_OUT);
  assign rsp.read_value     = rd_ok ? $signed(rd_sum) : '0;
  assign rsp.element_count  = count[POS_W-1:0];
  assign rsp.capacity_now   = cap[POS_W-1:0];
  assign rsp.is_empty       = (count == '0);
  assign rsp.status         = status;

endmodule

[src/pai_cell.sv]
// ----------------------------------------------------------------------------
// pai_cell: one entry of the array
// Holds a word, shifts up or down with its neighbors, loads or clears it,
// and offers it to the read tree when the request addresses this entry.
// ----------------------------------------------------------------------------
module pai_cell
  import pai_pkg::*;
#(
  parameter int IDX = 0,
  parameter int XW  = 11
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [XW-1:0]     pos,
  input  logic [XW-1:0]     fill_lo,
  input  logic [XW-1:0]     fill_hi,
  input  logic [WORD_W-1:0] from_left,
  input  logic [WORD_W-1:0] from_right,
  output logic [WORD_W-1:0] data,
  output logic [WORD_W-1:0] tap
);

  localparam logic [XW-1:0] ME = XW'(IDX);

  logic [WORD_W-1:0] data_next;

  // next entry value
  always_comb begin
    data_next = data;
    if (cmd.ins) begin
      if (ME > pos) data_next = from_left;
      else if (ME == pos) data_next = cmd.value;
    end else if (cmd.era) begin
      if (ME >= pos) data_next = from_right;
    end else if (cmd.set) begin
      if (ME == pos) data_next = cmd.value;
    end else if (cmd.fill) begin
      if (ME >= fill_lo && ME < fill_hi) data_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // addressed entry goes to the read tree
  assign tap = (ME == pos) ? data : '0;

endmodule

[src/pai_reduce.sv]
// ----------------------------------------------------------------------------
// pai_reduce: registered read tree
// Two registered levels of OR over groups of cell taps; only the addressed
// cell offers a nonzero word, so the OR yields that entry.
// ----------------------------------------------------------------------------
module pai_reduce
  import pai_pkg::*;
#(
  parameter int DEPTH = DEF_MAX_DEPTH
) (
  input  logic              clk,
  input  logic              load_grp,
  input  logic              load_sum,
  input  logic [WORD_W-1:0] taps [DEPTH],
  output logic [WORD_W-1:0] sum
);

  localparam int NG = (DEPTH + GROUP_N - 1) / GROUP_N;

  logic [WORD_W-1:0] pad [NG*GROUP_N];
  logic [WORD_W-1:0] grp [NG];
  logic [WORD_W-1:0] sum_next;

  // pad the taps up to whole groups
  genvar p;
  generate
    for (p = 0; p < NG*GROUP_N; p++) begin : g_pad
      if (p < DEPTH) begin : g_real
        assign pad[p] = taps[p];
      end else begin : g_zero
        assign pad[p] = '0;
      end
    end
  endgenerate

  // first level: one register per group
  genvar g;
  generate
    for (g = 0; g < NG; g++) begin : g_grp
      logic [WORD_W-1:0] acc;
      always_comb begin
        acc = '0;
        for (int k = 0; k < GROUP_N; k++) acc = acc | pad[g*GROUP_N + k];
      end
      always_ff @(posedge clk) begin
        if (load_grp) grp[g] <= acc;
      end
    end
  endgenerate

  // second level over the group registers
  always_comb begin
    sum_next = '0;
    for (int k = 0; k < NG; k++) sum_next = sum_next | grp[k];
  end

  always_ff @(posedge clk) begin
    if (load_sum) sum <= sum_next;
  end

endmodule

[src/pai_checker.sv]
// ----------------------------------------------------------------------------
// pai_checker: port-level checks of the positional array
// Watches the request and response channels and reports by error.
// ----------------------------------------------------------------------------
module pai_checker
  import pai_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp
);

  // a stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // empty flag follows the count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.is_empty == (rsp.element_count == '0)))
    else $error("empty flag does not match count");

  // count never exceeds capacity
  a_cap: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.element_count <= rsp.capacity_now))
    else $error("count above capacity");

  // one request at a time: no new request while a response waits
  a_single: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> req_stall)
    else $error("request taken while response pending");

  // a response never shows in the cycle after acceptance
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> !rsp_valid)
    else $error("response too early");

endmodule

bind positional_array_insert_erase pai_checker u_pai_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

[sim/pai_array_checker.sv]
// ----------------------------------------------------------------------------
// pai_array_checker: response predictor and comparator for the array block
// Watches both channels and mirrors every accepted request in a local copy
// of the array. The predicted responses are queued and compared, field by
// field and in order, with the responses that come back.
// ----------------------------------------------------------------------------
module pai_array_checker
  import pai_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  output int   fail_count,
  output int   pending
);

  localparam int DEPTH   = DEF_MAX_DEPTH;
  localparam int MIN_CAP = DEF_MIN_CAPACITY;

  // mirrored array state
  logic [WORD_W-1:0] slot_word [DEPTH];
  int unsigned       live_count = 0;
  int unsigned       cap_words  = MIN_CAP;

  rsp_t expected_rsp_q [$];
  int   err_total   = 0;
  int   outstanding = 0;

  assign fail_count = err_total;
  assign pending    = outstanding;

  // capacity steps, clamped to depth and minimum
  function automatic int unsigned cap_up(int unsigned c);
    int unsigned d;
    d = c * 2;
    return (d > DEPTH) ? DEPTH : d;
  endfunction

  function automatic int unsigned cap_down(int unsigned c);
    return (c / 2 < MIN_CAP) ? MIN_CAP : c / 2;
  endfunction

  // apply one request to the mirror and build its response
  function automatic rsp_t apply_array_op(req_t r);
    rsp_t        o;
    int unsigned p;
    int unsigned n;
    int unsigned i;
    p = r.position;
    n = r.resize_count;
    o = '0;
    o.status = ST_OK;
    case (r.kind)
      K_INSERT: begin
        if (live_count >= DEPTH) begin
          o.status = ST_FULL;
        end else if (p > live_count) begin
          o.status = ST_RANGE;
        end else begin
          if (live_count >= cap_words) cap_words = cap_up(cap_words);
          for (i = live_count; i > p; i--) slot_word[i] = slot_word[i-1];
          slot_word[p] = r.value;
          live_count++;
        end
      end
      K_ERASE: begin
        if (p >= live_count) begin
          o.status = ST_RANGE;
        end else begin
          o.read_value = slot_word[p];
          if (live_count - 1 < cap_words / 4 && cap_words > MIN_CAP)
            cap_words = cap_down(cap_words);
          for (i = p; i + 1 < live_count; i++) slot_word[i] = slot_word[i+1];
          live_count--;
        end
      end
      K_GET: begin
        if (p >= live_count) o.status = ST_RANGE;
        else o.read_value = slot_word[p];
      end
      K_SET: begin
        if (p >= live_count) o.status = ST_RANGE;
        else slot_word[p] = r.value;
      end
      K_RESIZE: begin
        if (n > DEPTH) begin
          o.status = ST_RANGE;
        end else begin
          // grow doubles until it fits, shrink halves while under a quarter
          while (n > cap_words) cap_words = cap_up(cap_words);
          while (n < live_count && n < cap_words / 4 && cap_words > MIN_CAP)
            cap_words = cap_down(cap_words);
          for (i = live_count; i < n; i++) slot_word[i] = '0;
          live_count = n;
        end
      end
      default: ;
    endcase
    o.element_count = POS_W'(live_count);
    o.capacity_now  = POS_W'(cap_words);
    o.is_empty      = (live_count == 0);
    return o;
  endfunction

  task automatic check_field(string name, logic signed [WORD_W:0] want,
                             logic signed [WORD_W:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_total++;
    end
  endtask

  // compare responses, then queue the prediction for a new request
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      live_count = 0;
      cap_words  = MIN_CAP;
      expected_rsp_q.delete();
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp_q.size() == 0) begin
          $display("%0t: response with no request waiting, actual %p", $time, rsp);
          err_total++;
        end else begin
          want = expected_rsp_q.pop_front();
          check_field("read_value", want.read_value, rsp.read_value);
          check_field("element_count", want.element_count, rsp.element_count);
          check_field("capacity_now", want.capacity_now, rsp.capacity_now);
          check_field("is_empty", want.is_empty, rsp.is_empty);
          check_field("status", want.status, rsp.status);
        end
      end
      if (req_valid && !req_stall) expected_rsp_q.push_back(apply_array_op(req));
    end
    outstanding <= expected_rsp_q.size();
  end

endmodule

[sim/tb_positional_array_insert_erase.sv]
// ----------------------------------------------------------------------------
// tb_positional_array_insert_erase: testbench of the positional array
// Directed requests for the edge cases, then random operation mixes under
// several idle and stall patterns and one long receiver hold-off. A separate
// checker predicts and compares; this top drives and reports the verdict.
// ----------------------------------------------------------------------------
module tb_positional_array_insert_erase;
  import pai_pkg::*;

  localparam int DEPTH          = DEF_MAX_DEPTH;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 16;

  // unassigned kind codes
  localparam logic [KIND_W-1:0] K_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] K_SPARE_HI = 3'd7;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  int fail_count;
  int pending;

  // traffic shaping
  int   idle_pct  = 0;
  int   stall_pct = 0;
  logic hold_go   = 1'b0;
  logic hold_used = 1'b0;
  int   hold_left = 0;
  int   quiet     = 0;

  // occupancy and written entries, used only to shape stimulus
  int unsigned shadow_count = 0;
  bit          entry_written [DEPTH];

  positional_array_insert_erase dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  pai_array_checker array_check (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // receiver: random stall, plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else if (hold_left != 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      rsp_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("[positional_array_insert_erase] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic req_t make_req(logic [KIND_W-1:0] k, int unsigned p,
                                    logic signed [WORD_W-1:0] v, int unsigned n);
    req_t r;
    r.kind         = k;
    r.position     = POS_W'(p);
    r.value        = v;
    r.resize_count = POS_W'(n);
    return r;
  endfunction

  // follow occupancy and which entries hold written data
  function automatic void track_request(req_t r);
    int unsigned p;
    int unsigned n;
    int unsigned i;
    p = r.position;
    n = r.resize_count;
    case (r.kind)
      K_INSERT: begin
        if (shadow_count < DEPTH && p <= shadow_count) begin
          for (i = shadow_count; i > p; i--) entry_written[i] = entry_written[i-1];
          entry_written[p] = 1'b1;
          shadow_count++;
        end
      end
      K_ERASE: begin
        if (p < shadow_count) begin
          for (i = p; i + 1 < shadow_count; i++) entry_written[i] = entry_written[i+1];
          shadow_count--;
        end
      end
      K_SET: begin
        if (p < shadow_count) entry_written[p] = 1'b1;
      end
      K_RESIZE: begin
        if (n <= DEPTH) begin
          // entries exposed by growth count as never written
          for (i = shadow_count; i < n; i++) entry_written[i] = 1'b0;
          shadow_count = n;
        end
      end
      default: ;
    endcase
  endfunction

  // mostly well-formed operations, some noise with bad kinds and positions
  function automatic req_t pick_random_request(bit drain_bias);
    req_t        r;
    int unsigned roll;
    int unsigned sel;
    int unsigned c;
    int unsigned lo;
    int unsigned hi;
    int unsigned ins_w;
    c = shadow_count;
    ins_w = drain_bias ? 22 : 38;
    r.kind         = K_GET;
    r.value        = $urandom;
    r.position     = POS_W'($urandom);
    r.resize_count = POS_W'($urandom);
    roll = $urandom_range(99);
    if (roll < ins_w) begin
      r.kind     = K_INSERT;
      r.position = POS_W'($urandom_range(c, 0));
    end else if (roll < 60) begin
      r.kind     = K_ERASE;
      r.position = (c == 0) ? '0 : POS_W'($urandom_range(c - 1, 0));
    end else if (roll < 72) begin
      r.kind     = K_GET;
      r.position = (c == 0) ? '0 : POS_W'($urandom_range(c - 1, 0));
    end else if (roll < 86) begin
      r.kind     = K_SET;
      r.position = (c == 0) ? '0 : POS_W'($urandom_range(c - 1, 0));
    end else if (roll < 94) begin
      r.kind = K_RESIZE;
      sel = $urandom_range(99);
      if (sel < 70) begin
        r.resize_count = POS_W'($urandom_range(48, 0));
      end else if (sel < 90) begin
        lo = (c > 8) ? c - 8 : 0;
        hi = (c + 8 > DEPTH) ? DEPTH : c + 8;
        r.resize_count = POS_W'($urandom_range(hi, lo));
      end else if (sel < 97) begin
        r.resize_count = POS_W'($urandom_range(DEPTH, 0));
      end else begin
        r.resize_count = POS_W'($urandom_range(2047, DEPTH + 1));
      end
    end else begin
      r.kind = KIND_W'($urandom_range(7, 0));
    end
    // never read an entry that holds no written data
    if ((r.kind == K_ERASE || r.kind == K_GET) && r.position < c &&
        !entry_written[r.position])
      r.kind = K_SET;
    return r;
  endfunction

  // offer one request and wait for it to be taken
  task automatic send_req(input req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    track_request(r);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    idle_pct  = 21;
    stall_pct <= 21;

    // empty array, bad positions, word extremes
    send_req(make_req(K_ERASE, 0, 0, 0));
    send_req(make_req(K_GET, 0, 0, 0));
    send_req(make_req(K_INSERT, 1, 5, 0));
    send_req(make_req(K_INSERT, 0, 32'sh7fffffff, 0));
    send_req(make_req(K_INSERT, 0, 32'sh80000000, 0));
    send_req(make_req(K_INSERT, 2, -1, 0));
    send_req(make_req(K_GET, 0, 0, 0));
    send_req(make_req(K_GET, 2, 0, 0));
    send_req(make_req(K_SET, 1, 0, 0));
    send_req(make_req(K_GET, 1, 0, 0));
    send_req(make_req(K_GET, 3, 0, 0));
    // erase every element, down to an empty array
    send_req(make_req(K_ERASE, 2, 0, 0));
    send_req(make_req(K_ERASE, 0, 0, 0));
    send_req(make_req(K_ERASE, 0, 0, 0));
    // resize beyond depth, to the same count, unknown kinds
    send_req(make_req(K_RESIZE, 0, 0, DEPTH + 1));
    send_req(make_req(K_RESIZE, 2047, -1, 2047));
    send_req(make_req(K_RESIZE, 0, 0, 0));
    send_req(make_req(K_SPARE_LO, 0, 0, 0));
    send_req(make_req(K_SPARE_HI, 2047, -1, 2047));
    // full depth
    send_req(make_req(K_RESIZE, 0, 0, DEPTH));
    send_req(make_req(K_INSERT, DEPTH, 9, 0));
    send_req(make_req(K_INSERT, 0, 9, 0));
    send_req(make_req(K_SET, DEPTH - 1, 32'sh12345678, 0));
    send_req(make_req(K_GET, DEPTH - 1, 0, 0));
    send_req(make_req(K_ERASE, DEPTH - 1, 0, 0));
    // shrink by resize, then halve by erase
    send_req(make_req(K_RESIZE, 0, 0, 16));
    send_req(make_req(K_SET, 0, 77, 0));
    send_req(make_req(K_ERASE, 0, 0, 0));
    send_req(make_req(K_RESIZE, 0, 0, 0));

    // random mixes, traffic pattern changes every hundred requests
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      case ((n / 100) % 4)
        0: begin
          idle_pct  = 0;
          stall_pct <= 0;
        end
        1: begin
          idle_pct  = 68;
          stall_pct <= 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct <= 68;
        end
        default: begin
          idle_pct  = 21;
          stall_pct <= 21;
        end
      endcase
      if (n == 30) hold_go <= 1'b1;
      send_req(pick_random_request((n / 250) % 2 == 1));
    end
    req_valid <= 1'b0;

    // drain outstanding responses
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[positional_array_insert_erase] OK");
    end else begin
      $display("[positional_array_insert_erase] ERROR");
    end
    $finish;
  end

endmodule

[positional_array_insert_erase.f]
src/pai_pkg.sv
src/pai_cell.sv
src/pai_reduce.sv
src/positional_array_insert_erase.sv
src/pai_checker.sv
sim/pai_array_checker.sv
sim/tb_positional_array_insert_erase.sv
